@@ hdl/oorsr_pkg.sv @@
// Shared constants, mode codes and the queued word type for the ordered op ring.
// No dependencies; every other file in hdl imports this package.
`default_nettype none

package oorsr_pkg;

   // Ring sizes (powers of two).
   localparam int OP_DEPTH   = 256;
   localparam int SIDE_DEPTH = 4096;
   localparam int OP_WIDTH   = 64;

   localparam int OP_AW   = $clog2(OP_DEPTH);
   localparam int OP_CW   = OP_AW + 1;
   localparam int SIDE_AW = $clog2(SIDE_DEPTH);
   localparam int SIDE_CW = SIDE_AW + 1;

   // Port field widths.
   localparam int MODE_W  = 3;
   localparam int OPS_W   = 9;
   localparam int WORDS_W = 13;
   localparam int DATA_W  = 64;
   localparam int OFFS_W  = 12;
   localparam int SEQ_W   = 32;
   localparam int DEPTH_W = 9;
   localparam int CNT_W   = 32;

   // Width of the room and wrap arithmetic.
   localparam int SUM_W = ((SIDE_CW > WORDS_W) ? SIDE_CW : WORDS_W) + 2;

   // Front-to-back queue.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Mode codes.
   localparam logic [MODE_W-1:0] MODE_CAN_ACCEPT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_RESERVE    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_PUSH       = 3'd2;
   localparam logic [MODE_W-1:0] MODE_PEEK       = 3'd3;
   localparam logic [MODE_W-1:0] MODE_POP        = 3'd4;
   localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd5;

   // A decoded word waiting for the back end.
   typedef struct packed {
      logic                 is_can;
      logic                 is_rsv;
      logic                 is_push;
      logic                 is_peek;
      logic                 is_pop;
      logic                 is_clr;
      logic [OPS_W-1:0]     op_count;
      logic [WORDS_W-1:0]   word_count;
      logic [OP_WIDTH-1:0]  op_data;
   } item_type;

endpackage

`default_nettype wire

@@ hdl/ordered_op_ring_with_side_reserve.sv @@
// A word leaves the input queue once the back end is free to take it; its response is
// registered as it is taken, or from ST_READ for a peek or pop that finds a slot.
// One word per cycle while the response register is free; a peek or pop of a queued slot
// holds off the next word for its ST_READ state because the slot store has one registered read port.
// Reset clears the queue, ring pointers, pending count, reject state and high-water mark;
// the slot stores keep whatever they hold and are read only after a push has written them.
`default_nettype none

module ordered_op_ring_with_side_reserve (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [oorsr_pkg::MODE_W-1:0]  req_mode,
   input  logic [oorsr_pkg::OPS_W-1:0]   req_op_count,
   input  logic [oorsr_pkg::WORDS_W-1:0] req_word_count,
   input  logic [oorsr_pkg::DATA_W-1:0]  req_op_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_ok,
   output logic [oorsr_pkg::OFFS_W-1:0]  rsp_side_offset,
   output logic [oorsr_pkg::DATA_W-1:0]  rsp_slot_op,
   output logic [oorsr_pkg::WORDS_W-1:0] rsp_slot_side_take,
   output logic [oorsr_pkg::SEQ_W-1:0]   rsp_slot_seq,
   output logic [oorsr_pkg::DEPTH_W-1:0] rsp_depth,
   output logic [oorsr_pkg::DEPTH_W-1:0] rsp_high_water,
   output logic                          rsp_reject_flag,
   output logic [oorsr_pkg::CNT_W-1:0]   rsp_reject_count
);
   import oorsr_pkg::*;

   logic     q_valid;
   logic     q_take;
   item_type q_item;

   oorsr_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_op_count   (req_op_count),
      .req_word_count (req_word_count),
      .req_op_data    (req_op_data),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_take         (q_take)
   );

   oorsr_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_take             (q_take),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_ok             (rsp_ok),
      .rsp_side_offset    (rsp_side_offset),
      .rsp_slot_op        (rsp_slot_op),
      .rsp_slot_side_take (rsp_slot_side_take),
      .rsp_slot_seq       (rsp_slot_seq),
      .rsp_depth          (rsp_depth),
      .rsp_high_water     (rsp_high_water),
      .rsp_reject_flag    (rsp_reject_flag),
      .rsp_reject_count   (rsp_reject_count)
   );

endmodule

`default_nettype wire

@@ hdl/oorsr_front.sv @@
// Front end: accepts request words, decodes the mode and holds them in a short queue.
// Depends on oorsr_pkg.
`default_nettype none

module oorsr_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [oorsr_pkg::MODE_W-1:0]  req_mode,
   input  logic [oorsr_pkg::OPS_W-1:0]   req_op_count,
   input  logic [oorsr_pkg::WORDS_W-1:0] req_word_count,
   input  logic [oorsr_pkg::DATA_W-1:0]  req_op_data,
   output logic                          q_valid,
   output oorsr_pkg::item_type           q_item,
   input  logic                          q_take
);
   import oorsr_pkg::*;

   item_type              slot_ff [QUEUE_DEPTH];
   item_type              dec_item;
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  enq;

   always_comb begin
      dec_item            = '0;
      dec_item.op_count   = req_op_count;
      dec_item.word_count = req_word_count;
      dec_item.op_data    = OP_WIDTH'(req_op_data);
      case (req_mode)
         MODE_CAN_ACCEPT: dec_item.is_can  = 1'b1;
         MODE_RESERVE:    dec_item.is_rsv  = 1'b1;
         MODE_PUSH:       dec_item.is_push = 1'b1;
         MODE_PEEK:       dec_item.is_peek = 1'b1;
         MODE_POP:        dec_item.is_pop  = 1'b1;
         MODE_CLEAR:      dec_item.is_clr  = 1'b1;
         default:         dec_item.is_can  = 1'b0;
      endcase
   end

   assign req_stall = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign enq       = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = enq    ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_AW+1)'(enq) - (QUEUE_AW+1)'(q_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         slot_ff[wr_ptr_ff] <= dec_item;
      end
   end

endmodule

`default_nettype wire

@@ hdl/oorsr_back.sv @@
// Back end: ring pointers, slot stores, reject tracking and the response register.
// Depends on oorsr_pkg; takes decoded words from oorsr_front.
`default_nettype none

module oorsr_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  oorsr_pkg::item_type           q_item,
   output logic                          q_take,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_ok,
   output logic [oorsr_pkg::OFFS_W-1:0]  rsp_side_offset,
   output logic [oorsr_pkg::DATA_W-1:0]  rsp_slot_op,
   output logic [oorsr_pkg::WORDS_W-1:0] rsp_slot_side_take,
   output logic [oorsr_pkg::SEQ_W-1:0]   rsp_slot_seq,
   output logic [oorsr_pkg::DEPTH_W-1:0] rsp_depth,
   output logic [oorsr_pkg::DEPTH_W-1:0] rsp_high_water,
   output logic                          rsp_reject_flag,
   output logic [oorsr_pkg::CNT_W-1:0]   rsp_reject_count
);
   import oorsr_pkg::*;

   localparam logic ST_RUN  = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic                 state_ff, state_in;
   logic                 pop_mode_ff, pop_mode_in;
   logic [SEQ_W-1:0]     op_head_ff, op_head_in;
   logic [OP_CW-1:0]     op_tail_ff, op_tail_in;
   logic [SIDE_CW-1:0]   side_head_ff, side_head_in;
   logic [SIDE_CW-1:0]   side_tail_ff, side_tail_in;
   logic [SIDE_CW-1:0]   pending_ff, pending_in;
   logic                 sticky_ff, sticky_in;
   logic [CNT_W-1:0]     reject_ff, reject_in;
   logic [OP_CW-1:0]     peak_ff, peak_in;

   logic [OP_WIDTH-1:0]  op_mem   [OP_DEPTH];
   logic [SIDE_CW-1:0]   take_mem [OP_DEPTH];
   logic [SEQ_W-1:0]     seq_mem  [OP_DEPTH];
   logic [OP_WIDTH-1:0]  rd_op_ff;
   logic [SIDE_CW-1:0]   rd_take_ff;
   logic [SEQ_W-1:0]     rd_seq_ff;
   logic                 mem_we;

   logic                 rsp_valid_ff;
   logic                 ok_ff, ok_in;
   logic [OFFS_W-1:0]    offset_ff, offset_in;
   logic [DATA_W-1:0]    slot_op_ff, slot_op_in;
   logic [WORDS_W-1:0]   slot_take_ff, slot_take_in;
   logic [SEQ_W-1:0]     slot_seq_ff, slot_seq_in;
   logic                 load;

   logic                 out_free;
   logic [OP_CW-1:0]     used;
   logic [OP_CW-1:0]     new_used;
   logic [SIDE_CW-1:0]   ring_fill;
   logic [SIDE_CW-1:0]   start;
   logic [SIDE_AW-1:0]   idx;
   logic [SUM_W-1:0]     words;
   logic [SUM_W-1:0]     need;
   logic [SUM_W-1:0]     pad;
   logic [SUM_W-1:0]     total;
   logic [SIDE_AW-1:0]   grant_off;
   logic                 room_ok;
   logic                 reject;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign used      = op_head_ff[OP_CW-1:0] - op_tail_ff;
   assign new_used  = used + 1'b1;
   assign ring_fill = side_head_ff - side_tail_ff;
   assign words     = SUM_W'(q_item.word_count);

   // Worst case for a can-accept check assumes a pad of one word less than the request.
   always_comb begin
      need    = (words == '0) ? '0 : (words << 1) - 1'b1;
      room_ok = ((SUM_W'(used) + SUM_W'(q_item.op_count)) <= SUM_W'(OP_DEPTH)) &&
                ((SUM_W'(ring_fill) + SUM_W'(pending_ff) + need) <= SUM_W'(SIDE_DEPTH));
   end

   // A reserve that would run past the ring edge pads to the edge and starts at zero.
   always_comb begin
      start = side_head_ff + pending_ff;
      idx   = start[SIDE_AW-1:0];
      if ((SUM_W'(idx) + words) > SUM_W'(SIDE_DEPTH)) begin
         pad       = SUM_W'(SIDE_DEPTH) - SUM_W'(idx);
         grant_off = '0;
      end else begin
         pad       = '0;
         grant_off = idx;
      end
      total = SUM_W'(SIDE_CW'(start - side_tail_ff)) + pad + words;
   end

   always_comb begin
      state_in     = state_ff;
      pop_mode_in  = pop_mode_ff;
      op_head_in   = op_head_ff;
      op_tail_in   = op_tail_ff;
      side_head_in = side_head_ff;
      side_tail_in = side_tail_ff;
      pending_in   = pending_ff;
      sticky_in    = sticky_ff;
      reject_in    = reject_ff;
      peak_in      = peak_ff;
      q_take       = 1'b0;
      load         = 1'b0;
      mem_we       = 1'b0;
      reject       = 1'b0;
      ok_in        = 1'b0;
      offset_in    = '0;
      slot_op_in   = '0;
      slot_take_in = '0;
      slot_seq_in  = '0;
      case (state_ff)
         ST_RUN: begin
            if (q_valid && out_free) begin
               q_take = 1'b1;
               if ((q_item.is_peek || q_item.is_pop) && used != '0) begin
                  // The slot store read is registered, so the result is loaded in the next cycle, from ST_READ.
                  state_in    = ST_READ;
                  pop_mode_in = q_item.is_pop;
               end else begin
                  load = 1'b1;
                  if (q_item.is_can) begin
                     ok_in = room_ok;
                  end else if (q_item.is_rsv) begin
                     if (words == '0) begin
                        ok_in = 1'b1;
                     end else if (total > SUM_W'(SIDE_DEPTH)) begin
                        reject = 1'b1;
                     end else begin
                        pending_in = SIDE_CW'(SUM_W'(pending_ff) + pad + words);
                        ok_in      = 1'b1;
                        offset_in  = OFFS_W'(grant_off);
                     end
                  end else if (q_item.is_push) begin
                     if (SUM_W'(used) >= SUM_W'(OP_DEPTH)) begin
                        reject = 1'b1;
                     end else begin
                        mem_we       = 1'b1;
                        side_head_in = side_head_ff + pending_ff;
                        pending_in   = '0;
                        op_head_in   = op_head_ff + 1'b1;
                        if (new_used > peak_ff) begin
                           peak_in = new_used;
                        end
                        ok_in = 1'b1;
                     end
                  end else if (q_item.is_clr) begin
                     sticky_in = 1'b0;
                     ok_in     = 1'b1;
                  end
                  if (reject) begin
                     sticky_in = 1'b1;
                     reject_in = reject_ff + 1'b1;
                  end
               end
            end
         end
         ST_READ: begin
            load         = 1'b1;
            ok_in        = 1'b1;
            slot_op_in   = DATA_W'(rd_op_ff);
            slot_take_in = WORDS_W'(rd_take_ff);
            slot_seq_in  = rd_seq_ff;
            if (pop_mode_ff) begin
               op_tail_in   = op_tail_ff + 1'b1;
               side_tail_in = side_tail_ff + rd_take_ff;
            end
            state_in = ST_RUN;
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         pop_mode_ff  <= 1'b0;
         op_head_ff   <= '0;
         op_tail_ff   <= '0;
         side_head_ff <= '0;
         side_tail_ff <= '0;
         pending_ff   <= '0;
         sticky_ff    <= 1'b0;
         reject_ff    <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pop_mode_ff  <= pop_mode_in;
         op_head_ff   <= op_head_in;
         op_tail_ff   <= op_tail_in;
         side_head_ff <= side_head_in;
         side_tail_ff <= side_tail_in;
         pending_ff   <= pending_in;
         sticky_ff    <= sticky_in;
         reject_ff    <= reject_in;
         peak_ff      <= peak_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ok_ff        <= ok_in;
         offset_ff    <= offset_in;
         slot_op_ff   <= slot_op_in;
         slot_take_ff <= slot_take_in;
         slot_seq_ff  <= slot_seq_in;
      end
   end

   // Slot stores: written at the head on a push, read at the tail every cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         op_mem[op_head_ff[OP_AW-1:0]]   <= q_item.op_data;
         take_mem[op_head_ff[OP_AW-1:0]] <= pending_ff;
         seq_mem[op_head_ff[OP_AW-1:0]]  <= op_head_ff;
      end
      rd_op_ff   <= op_mem[op_tail_ff[OP_AW-1:0]];
      rd_take_ff <= take_mem[op_tail_ff[OP_AW-1:0]];
      rd_seq_ff  <= seq_mem[op_tail_ff[OP_AW-1:0]];
   end

   // The status fields change only when a new response loads, so they read straight
   // from the state registers.
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = ok_ff;
   assign rsp_side_offset    = offset_ff;
   assign rsp_slot_op        = slot_op_ff;
   assign rsp_slot_side_take = slot_take_ff;
   assign rsp_slot_seq       = slot_seq_ff;
   assign rsp_depth          = DEPTH_W'(used);
   assign rsp_high_water     = DEPTH_W'(peak_ff);
   assign rsp_reject_flag    = sticky_ff;
   assign rsp_reject_count   = reject_ff;

endmodule

`default_nettype wire

@@ hdl/oorsr_checker.sv @@
// Port-level checks for the ordered op ring, attached to the top level by a bind.
// Depends on oorsr_pkg and ordered_op_ring_with_side_reserve.
`default_nettype none

module oorsr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_ok,
   input logic [oorsr_pkg::OFFS_W-1:0]  rsp_side_offset,
   input logic [oorsr_pkg::DEPTH_W-1:0] rsp_depth,
   input logic [oorsr_pkg::DEPTH_W-1:0] rsp_high_water
);
   import oorsr_pkg::*;

   // No response survives a reset.
   a_reset_clears : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response still valid after reset");

   // The queue can never hold more ops than it has slots.
   a_depth_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_depth <= DEPTH_W'(OP_DEPTH)))
      else $error("depth exceeds queue size");

   // Depth only grows through a push, so it never passes the high-water mark.
   a_depth_below_peak : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_depth <= rsp_high_water))
      else $error("depth above high-water mark");

   // A nonzero side offset comes only from a granted reserve.
   a_offset_needs_ok : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_side_offset != '0) |-> rsp_ok)
      else $error("side offset on a failed word");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_ok) && $stable(rsp_depth)))
      else $error("stalled response changed");

endmodule

bind ordered_op_ring_with_side_reserve oorsr_checker u_oorsr_checker (.*);

`default_nettype wire

@@ sim/tb.sv @@
// Self-checking bench for ordered_op_ring_with_side_reserve: drives mode words with bursty
// valid and a patterned rsp_stall, predicts every reply and compares it field by field.
// Depends on oorsr_pkg and the block's RTL only.

module tb;
   import oorsr_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED_A = 3'd6;
   localparam logic [MODE_W-1:0] MODE_UNUSED_B = 3'd7;
   localparam int unsigned LONG_HOLD   = 400;
   localparam int unsigned QUIET_LIMIT = 3000;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [OPS_W-1:0]   op_count;
      logic [WORDS_W-1:0] word_count;
      logic [DATA_W-1:0]  op_data;
   } ring_cmd_type;

   typedef struct packed {
      logic               ok;
      logic [OFFS_W-1:0]  side_offset;
      logic [DATA_W-1:0]  slot_op;
      logic [WORDS_W-1:0] slot_side_take;
      logic [SEQ_W-1:0]   slot_seq;
      logic [DEPTH_W-1:0] depth;
      logic [DEPTH_W-1:0] high_water;
      logic               reject_flag;
      logic [CNT_W-1:0]   reject_count;
   } ring_reply_type;

   typedef enum {PH_FILL, PH_DRAIN, PH_MIX} phase_type;

   // Tracks the op queue and side ring and keeps the replies still owed by the block.
   class ring_tracker_type;
      logic [DATA_W-1:0]  slot_data[OP_DEPTH];
      logic [WORDS_W-1:0] slot_take[OP_DEPTH];
      logic [SEQ_W-1:0]   slot_seq_no[OP_DEPTH];
      bit [31:0]          head_count, tail_count, side_wr, side_rd;
      bit [WORDS_W-1:0]   words_held;
      bit                 sticky;
      bit [31:0]          rejects;
      bit [DEPTH_W-1:0]   peak;
      ring_reply_type     replies_due[$];
      int unsigned        fails;

      function ring_reply_type predict_reply(ring_cmd_type w);
         ring_reply_type r;
         bit [31:0] used, start, span, ring_fill;
         longint unsigned words, need, idx, pad, total;
         int slot;
         r = '0;
         used = head_count - tail_count;
         words = w.word_count;
         case (w.mode)
            MODE_CAN_ACCEPT: begin
               ring_fill = side_wr - side_rd;
               need = words + ((words != 0) ? words - 1 : 0);
               r.ok = (longint'(used) + w.op_count <= OP_DEPTH) &&
                      (longint'(ring_fill) + words_held + need <= SIDE_DEPTH);
            end
            MODE_RESERVE: begin
               if (words == 0) begin
                  r.ok = 1'b1;
               end else begin
                  start = side_wr + words_held;
                  idx = start & (SIDE_DEPTH - 1);
                  pad = 0;
                  // A block that would run past the ring edge starts over at zero.
                  if (idx + words > SIDE_DEPTH) begin
                     pad = SIDE_DEPTH - idx;
                     idx = 0;
                  end
                  span = start - side_rd;
                  total = longint'(span) + pad + words;
                  if (total > SIDE_DEPTH) begin
                     sticky = 1'b1;
                     rejects++;
                  end else begin
                     words_held += WORDS_W'(pad + words);
                     r.ok = 1'b1;
                     r.side_offset = OFFS_W'(idx);
                  end
               end
            end
            MODE_PUSH: begin
               if (used >= OP_DEPTH) begin
                  sticky = 1'b1;
                  rejects++;
               end else begin
                  slot = head_count % OP_DEPTH;
                  slot_data[slot] = w.op_data;
                  slot_take[slot] = words_held;
                  slot_seq_no[slot] = head_count;
                  side_wr += words_held;
                  words_held = '0;
                  head_count++;
                  used = head_count - tail_count;
                  if (used > peak) peak = DEPTH_W'(used);
                  r.ok = 1'b1;
               end
            end
            MODE_PEEK, MODE_POP: begin
               if (used != 0) begin
                  slot = tail_count % OP_DEPTH;
                  r.slot_op = slot_data[slot];
                  r.slot_side_take = slot_take[slot];
                  r.slot_seq = slot_seq_no[slot];
                  r.ok = 1'b1;
                  if (w.mode == MODE_POP) begin
                     side_rd += slot_take[slot];
                     tail_count++;
                  end
               end
            end
            MODE_CLEAR: begin
               sticky = 1'b0;
               r.ok = 1'b1;
            end
            default: ;
         endcase
         used = head_count - tail_count;
         r.depth = DEPTH_W'(used);
         r.high_water = peak;
         r.reject_flag = sticky;
         r.reject_count = rejects;
         return r;
      endfunction

      function void note_word(ring_cmd_type w);
         replies_due.push_back(predict_reply(w));
      endfunction

      function void check_field(string field, longint unsigned want, longint unsigned got);
         if (want != got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            fails++;
         end
      endfunction

      function void check_result(ring_reply_type got);
         ring_reply_type want;
         if (replies_due.size() == 0) begin
            $error("reply word arrived with none outstanding");
            fails++;
            return;
         end
         want = replies_due.pop_front();
         check_field("ok", want.ok, got.ok);
         check_field("side_offset", want.side_offset, got.side_offset);
         check_field("slot_op", want.slot_op, got.slot_op);
         check_field("slot_side_take", want.slot_side_take, got.slot_side_take);
         check_field("slot_seq", want.slot_seq, got.slot_seq);
         check_field("depth", want.depth, got.depth);
         check_field("high_water", want.high_water, got.high_water);
         check_field("reject_flag", want.reject_flag, got.reject_flag);
         check_field("reject_count", want.reject_count, got.reject_count);
      endfunction

      function int unsigned outstanding();
         return replies_due.size();
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [MODE_W-1:0]    req_mode = MODE_CAN_ACCEPT;
   logic [OPS_W-1:0]     req_op_count = '0;
   logic [WORDS_W-1:0]   req_word_count = '0;
   logic [DATA_W-1:0]    req_op_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_ok;
   logic [OFFS_W-1:0]    rsp_side_offset;
   logic [DATA_W-1:0]    rsp_slot_op;
   logic [WORDS_W-1:0]   rsp_slot_side_take;
   logic [SEQ_W-1:0]     rsp_slot_seq;
   logic [DEPTH_W-1:0]   rsp_depth;
   logic [DEPTH_W-1:0]   rsp_high_water;
   logic                 rsp_reject_flag;
   logic [CNT_W-1:0]     rsp_reject_count;

   ring_tracker_type tracker = new;
   ring_reply_type seen_reply;
   int unsigned quiet_cycles = 0;
   int unsigned hold_asks = 0, hold_taken = 0, hold_left = 0;
   int unsigned pat_left = 0, pat_kind = 0;

   ordered_op_ring_with_side_reserve dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_op_count       (req_op_count),
      .req_word_count     (req_word_count),
      .req_op_data        (req_op_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_ok             (rsp_ok),
      .rsp_side_offset    (rsp_side_offset),
      .rsp_slot_op        (rsp_slot_op),
      .rsp_slot_side_take (rsp_slot_side_take),
      .rsp_slot_seq       (rsp_slot_seq),
      .rsp_depth          (rsp_depth),
      .rsp_high_water     (rsp_high_water),
      .rsp_reject_flag    (rsp_reject_flag),
      .rsp_reject_count   (rsp_reject_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_reply.ok = rsp_ok;
         seen_reply.side_offset = rsp_side_offset;
         seen_reply.slot_op = rsp_slot_op;
         seen_reply.slot_side_take = rsp_slot_side_take;
         seen_reply.slot_seq = rsp_slot_seq;
         seen_reply.depth = rsp_depth;
         seen_reply.high_water = rsp_high_water;
         seen_reply.reject_flag = rsp_reject_flag;
         seen_reply.reject_count = rsp_reject_count;
         tracker.check_result(seen_reply);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // The receiver switches among stall patterns and takes one long hold on request.
   always @(negedge clock) begin
      if (hold_taken != hold_asks) begin
         hold_taken = hold_asks;
         hold_left = LONG_HOLD;
      end
      if (pat_left == 0) begin
         pat_left = $urandom_range(8, 120);
         pat_kind = $urandom_range(3);
      end else begin
         pat_left--;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (pat_kind)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(3) == 0);
            2: rsp_stall <= ($urandom_range(3) != 0);
            default: rsp_stall <= pat_left[0];
         endcase
      end
   end

   function automatic ring_cmd_type mk_cmd(logic [MODE_W-1:0] mode, int unsigned ops,
                                           int unsigned words, logic [DATA_W-1:0] data);
      ring_cmd_type w;
      w.mode = mode;
      w.op_count = OPS_W'(ops);
      w.word_count = WORDS_W'(words);
      w.op_data = data;
      return w;
   endfunction

   function automatic ring_cmd_type gen_word(phase_type ph);
      ring_cmd_type w;
      int unsigned cut[6];
      int unsigned roll, sz;
      case (ph)
         PH_FILL:  cut = '{5, 18, 83, 87, 89, 96};
         PH_DRAIN: cut = '{5, 10, 15, 22, 92, 97};
         default:  cut = '{12, 35, 50, 60, 88, 95};
      endcase
      roll = $urandom_range(99);
      if (roll < cut[0])      w.mode = MODE_CAN_ACCEPT;
      else if (roll < cut[1]) w.mode = MODE_RESERVE;
      else if (roll < cut[2]) w.mode = MODE_PUSH;
      else if (roll < cut[3]) w.mode = MODE_PEEK;
      else if (roll < cut[4]) w.mode = MODE_POP;
      else if (roll < cut[5]) w.mode = MODE_CLEAR;
      else                    w.mode = roll[0] ? MODE_UNUSED_A : MODE_UNUSED_B;
      w.op_count = ($urandom_range(9) == 0) ? OPS_W'(OP_DEPTH)
                                             : OPS_W'($urandom_range(OP_DEPTH));
      sz = $urandom_range(19);
      if (ph == PH_FILL)  w.word_count = WORDS_W'($urandom_range(16));
      else if (sz < 10)   w.word_count = WORDS_W'($urandom_range(48));
      else if (sz < 14)   w.word_count = WORDS_W'($urandom_range(600));
      else if (sz < 17)   w.word_count = WORDS_W'($urandom_range(SIDE_DEPTH));
      else if (sz == 17)  w.word_count = WORDS_W'(SIDE_DEPTH);
      else if (sz == 18)  w.word_count = WORDS_W'(1);
      else                w.word_count = '0;
      sz = $urandom_range(19);
      if (sz == 0)      w.op_data = '1;
      else if (sz == 1) w.op_data = '0;
      else              w.op_data = {$urandom, $urandom};
      return w;
   endfunction

   // Called just after a falling edge; returns just after the falling edge that follows
   // acceptance.
   task automatic send_word(ring_cmd_type w);
      req_valid <= 1'b1;
      req_mode <= w.mode;
      req_op_count <= w.op_count;
      req_word_count <= w.word_count;
      req_op_data <= w.op_data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_word(w);
      @(negedge clock);
   endtask

   task automatic idle_sender(int unsigned n);
      req_valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic wait_for_replies();
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic run_phase(phase_type ph, int unsigned n_items, bit gaps);
      int unsigned sent, burst;
      ring_cmd_type w;
      sent = 0;
      while (sent < n_items) begin
         burst = $urandom_range(1, 24);
         while (burst != 0 && sent < n_items) begin
            w = gen_word(ph);
            send_word(w);
            sent++;
            burst--;
            // Most reserves are followed by the push that claims them.
            if (w.mode == MODE_RESERVE && $urandom_range(9) < 7) begin
               w = gen_word(ph);
               w.mode = MODE_PUSH;
               send_word(w);
               sent++;
            end
         end
         if (gaps && $urandom_range(3) != 0) idle_sender($urandom_range(1, 6));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_word(mk_cmd(MODE_PEEK, 0, 0, '0));
      send_word(mk_cmd(MODE_POP, 0, 0, '0));
      send_word(mk_cmd(MODE_CAN_ACCEPT, 0, 0, '0));
      send_word(mk_cmd(MODE_CAN_ACCEPT, OP_DEPTH, SIDE_DEPTH, '0));
      send_word(mk_cmd(MODE_CAN_ACCEPT, OP_DEPTH, 0, '0));
      send_word(mk_cmd(MODE_CAN_ACCEPT, 0, SIDE_DEPTH / 2, '0));
      send_word(mk_cmd(MODE_CAN_ACCEPT, 1, SIDE_DEPTH / 2 + 1, '0));
      send_word(mk_cmd(MODE_RESERVE, 0, 0, '0));
      send_word(mk_cmd(MODE_RESERVE, 0, SIDE_DEPTH, '0));
      send_word(mk_cmd(MODE_RESERVE, 0, 1, '0));
      send_word(mk_cmd(MODE_CLEAR, 0, 0, '0));
      send_word(mk_cmd(MODE_PUSH, 0, 0, '1));
      send_word(mk_cmd(MODE_PUSH, 0, 0, '0));
      send_word(mk_cmd(MODE_PEEK, 0, 0, '0));
      send_word(mk_cmd(MODE_POP, 0, 0, '0));
      send_word(mk_cmd(MODE_RESERVE, 0, 3000, '0));
      send_word(mk_cmd(MODE_PUSH, 0, 0, 64'hAAAA_AAAA_AAAA_AAAA));
      send_word(mk_cmd(MODE_POP, 0, 0, '0));
      send_word(mk_cmd(MODE_POP, 0, 0, '0));
      // This one runs past the ring edge and must be padded back to offset zero.
      send_word(mk_cmd(MODE_RESERVE, 0, 2000, '0));
      send_word(mk_cmd(MODE_PUSH, 0, 0, 64'h5555_5555_5555_5555));
      send_word(mk_cmd(MODE_UNUSED_A, OP_DEPTH, SIDE_DEPTH, '1));
      send_word(mk_cmd(MODE_UNUSED_B, 5, 7, 64'h1234));
      send_word(mk_cmd(MODE_CAN_ACCEPT, OP_DEPTH - 1, 1, '0));
      send_word(mk_cmd(MODE_PEEK, 0, 0, '0));
      wait_for_replies();

      // Hold the receiver off while the queue is being filled so the input backs up.
      hold_asks++;
      run_phase(PH_FILL, 380, 1'b0);
      run_phase(PH_DRAIN, 400, 1'b1);
      run_phase(PH_MIX, 250, 1'b1);
      wait_for_replies();
      run_phase(PH_FILL, 150, 1'b1);
      run_phase(PH_MIX, 150, 1'b0);

      wait_for_replies();
      repeat (8) @(posedge clock);
      if (tracker.fails == 0 && tracker.outstanding() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
